// File: rtl/tle_pkg.sv
// shared constants, types and command/status structs for the line edit buffer
package tle_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] HELP_RST = 8'h3F;

  localparam logic KIND_CHAR     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic fetch;      // read store at current index
    logic load_char;  // load output register from read data
    logic advance;    // step index
  } cmd_t;

  typedef struct packed {
    logic emit_start; // accepted byte completes a non-empty line
    logic ovf_start;  // accepted byte ends an overflowed line
    logic skip;       // read data is a leading blank
    logic at_last;    // index is at the final character
    logic out_taken;  // output transaction this cycle
    logic out_last;   // output register holds the final item
  } sts_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_bs(input logic [7:0] c);
    return (c == CH_BS) || (c == CH_DEL);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

// File: rtl/tle_ctrl.sv
// controller state machine for byte intake and line emission
module tle_ctrl import tle_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.emit_start) begin
            state_nxt = ST_FETCH;
          end else if (sts.ovf_start) begin
            state_nxt = ST_SEND;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.skip) begin
          state_nxt = sts.at_last ? ST_IDLE : ST_FETCH;
        end else begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (sts.out_taken) begin
          state_nxt = sts.out_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_CHECK: begin
        cmd.load_char = !sts.skip;
        cmd.advance   = sts.skip && !sts.at_last;
      end
      ST_SEND: begin
        cmd.advance = sts.out_taken && !sts.out_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/tle_dp.sv
// datapath: line store, edit state, scan index and output register
module tle_dp import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_help_char,
  input  logic [7:0] in_char_in,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_kind,
  output logic       out_is_help,
  output logic       out_last
);

  logic [7:0]       mem [LINE_CAPACITY];
  logic [7:0]       help_char_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_eol_r, last_eol_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] idx_r;
  logic [7:0]       rd_data_r;
  logic             found_r;
  logic             help_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_kind_r;
  logic             out_help_r;
  logic             out_last_r;

  logic full, ovf_eff, c_eol, c_bs, do_store, help_now, out_taken;

  assign c_eol   = is_eol(in_char_in);
  assign c_bs    = is_bs(in_char_in);
  assign full    = (count_r == CNT_W'(LINE_CAPACITY));
  // a full line turns any byte but 0x08 into overflow
  assign ovf_eff = ovf_r || (full && (in_char_in != CH_BS));
  assign do_store = cmd.accept && !ovf_eff && !c_bs && !c_eol;

  always_comb begin
    count_nxt    = count_r;
    last_eol_nxt = last_eol_r;
    ovf_nxt      = ovf_r;
    if (ovf_eff) begin
      if (c_eol) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        ovf_nxt      = 1'b1;
        last_eol_nxt = 1'b0;
      end
    end else if (c_bs) begin
      if (!last_eol_r && (count_r != '0)) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (c_eol) begin
      if (!last_eol_r) begin
        count_nxt    = '0;
        last_eol_nxt = 1'b1;
      end
    end else begin
      count_nxt    = count_r + CNT_W'(1);
      last_eol_nxt = 1'b0;
    end
  end

  assign help_now  = found_r ? help_r : (rd_data_r == help_char_r);
  assign out_taken = out_valid_r && !out_stall;

  always_comb begin
    sts.emit_start = !ovf_eff && !c_bs && c_eol && !last_eol_r && (count_r != '0);
    sts.ovf_start  = ovf_eff && c_eol;
    sts.skip       = !found_r && is_blank(rd_data_r);
    sts.at_last    = ((idx_r + CNT_W'(1)) == len_r);
    sts.out_taken  = out_taken;
    sts.out_last   = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      help_char_r <= HELP_RST;
      count_r     <= '0;
      last_eol_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        help_char_r <= cfg_help_char;
      end
      if (cmd.accept) begin
        count_r    <= count_nxt;
        last_eol_r <= last_eol_nxt;
        ovf_r      <= ovf_nxt;
      end
      if ((cmd.accept && sts.ovf_start) || cmd.load_char) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[count_r[ADDR_W-1:0]] <= in_char_in;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit_start) begin
      len_r   <= count_r;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.load_char) begin
      found_r <= 1'b1;
      help_r  <= help_now;
    end
    if (cmd.accept && sts.ovf_start) begin
      out_char_r <= CH_NUL;
      out_kind_r <= KIND_OVERFLOW;
      out_help_r <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.load_char) begin
      out_char_r <= rd_data_r;
      out_kind_r <= KIND_CHAR;
      out_help_r <= help_now;
      out_last_r <= sts.at_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_kind     = out_kind_r;
  assign out_is_help  = out_help_r;
  assign out_last     = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LINE_CAPACITY))
    else $error("line count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow mode with a line that is not full");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.emit_start |=> (count_r == '0) && last_eol_r && !ovf_r)
    else $error("line not cleared after end of line");

  a_fetch_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> (idx_r < len_r))
    else $error("store read past end of completed line");

endmodule

// File: rtl/tty_line_edit_buffer.sv
// top level of the terminal line edit buffer
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | input     | in_valid/in_stall  | in_char_in
//   out     | output    | out_valid/out_stall| out_char_out, out_kind, out_is_help,
//           |           |                    | out_last
//   cfg     | input     | cfg_wr_en          | cfg_help_char
//
// a byte that causes no result leaves the controller idle; the next byte is taken the cycle after
// a completed line is scanned through FETCH and CHECK per character, leading blanks skipped,
//   other characters also pass SEND; the line store read is registered and feeds the output register
// an overflow result is loaded in the accept cycle and shown the cycle after
// rst_n is synchronous: line empty, no overflow, help character back to '?'
// out_stall holds the output register; in_stall is high until the run is delivered
module tty_line_edit_buffer import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_help_char,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_kind,
  output logic       out_is_help,
  output logic       out_last
);

  cmd_t cmd;
  sts_t sts;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tle_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_help_char (cfg_help_char),
    .in_char_in    (in_char_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_kind      (out_kind),
    .out_is_help   (out_is_help),
    .out_last      (out_last)
  );

endmodule
